### rtl/htmt_pkg.sv
// Shared types, constants and the quarter-wave cosine table for the
// transfer-matrix trace block. No dependencies.
package htmt_pkg;

  localparam int unsigned PeriodMax = 64;
  localparam int unsigned Quarter   = 256;

  localparam logic [47:0] EntLim    = 48'h7FFF_FFFF_FFFF;
  localparam logic [63:0] HalfPiQ30 = 64'd1686629713;

  localparam logic [1:0] CFG_ALPHA  = 2'd0;
  localparam logic [1:0] CFG_PERIOD = 2'd1;
  localparam logic [1:0] CFG_PHASE  = 2'd2;

  typedef logic [30:0] cos_tab_t [0:256];

  typedef struct packed {
    logic       init;
    logic       mod_step;
    logic       div_step;
    logic       div_first;
    logic       angle;
    logic       dset;
    logic       mul_step;
    logic       mul_first;
    logic       round;
    logic       write;
    logic       next;
    logic       trace;
    logic       row;
    logic [3:0] idx;
  } ctrl_cmd_t;

  typedef struct packed {
    logic last_site;
  } dp_status_t;

  function automatic cos_tab_t build_cos_tab();
    cos_tab_t           t;
    logic [63:0]        theta;
    logic [63:0]        t2;
    logic [63:0]        term;
    logic [63:0]        tmp;
    logic signed [63:0] sum;
    for (int k = 0; k <= 256; k++) begin
      theta = (64'(k) * HalfPiQ30 + 64'd128) >> 8;
      t2    = (theta * theta + (64'd1 << 29)) >> 30;
      term  = 64'd1 << 30;
      sum   = signed'(term);
      for (int n = 1; n <= 8; n++) begin
        tmp = (term * t2) >> 30;
        case (n)
          1:       term = tmp / 64'd2;
          2:       term = tmp / 64'd12;
          3:       term = tmp / 64'd30;
          4:       term = tmp / 64'd56;
          5:       term = tmp / 64'd90;
          6:       term = tmp / 64'd132;
          7:       term = tmp / 64'd182;
          default: term = tmp / 64'd240;
        endcase
        if ((n % 2) == 1) sum = sum - signed'(term);
        else sum = sum + signed'(term);
      end
      if (sum < 0) sum = 0;
      if (sum > (64'sd1 <<< 30)) sum = 64'sd1 <<< 30;
      t[k] = sum[30:0];
    end
    return t;
  endfunction

  localparam cos_tab_t CosTab = build_cos_tab();

endpackage

### rtl/htmt_ctrl.sv
// Sequencer for the transfer-matrix trace: steps the datapath through
// reduction, division, per-site matrix update and trace. Uses htmt_pkg.
module htmt_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  output logic                  busy_o,
  output htmt_pkg::ctrl_cmd_t   cmd_o,
  input  htmt_pkg::dp_status_t  status_i
);

  typedef enum logic [9:0] {
    S_IDLE  = 10'b00_0000_0001,
    S_MOD   = 10'b00_0000_0010,
    S_DIV   = 10'b00_0000_0100,
    S_ANGLE = 10'b00_0000_1000,
    S_DSET  = 10'b00_0001_0000,
    S_MUL   = 10'b00_0010_0000,
    S_ROUND = 10'b00_0100_0000,
    S_WRITE = 10'b00_1000_0000,
    S_NEXT  = 10'b01_0000_0000,
    S_TRACE = 10'b10_0000_0000
  } state_e;

  state_e     state_q, state_d;
  logic [3:0] cnt_q, cnt_d;
  logic       row_q, row_d;

  always_comb begin
    state_d   = state_q;
    cnt_d     = cnt_q;
    row_d     = row_q;
    cmd_o     = '0;
    cmd_o.row = row_q;
    cmd_o.idx = cnt_q;
    case (state_q)
      S_IDLE: begin
        if (start_i) begin
          cmd_o.init = 1'b1;
          cnt_d      = 4'd5;
          state_d    = S_MOD;
        end
      end
      S_MOD: begin
        cmd_o.mod_step = 1'b1;
        if (cnt_q == 4'd0) begin
          cnt_d   = 4'd15;
          state_d = S_DIV;
        end else begin
          cnt_d = cnt_q - 4'd1;
        end
      end
      S_DIV: begin
        cmd_o.div_step  = 1'b1;
        cmd_o.div_first = (cnt_q == 4'd15);
        cnt_d           = cnt_q - 4'd1;
        if (cnt_q == 4'd0) state_d = S_ANGLE;
      end
      S_ANGLE: begin
        cmd_o.angle = 1'b1;
        state_d     = S_DSET;
      end
      S_DSET: begin
        cmd_o.dset = 1'b1;
        cnt_d      = 4'd3;
        row_d      = 1'b0;
        state_d    = S_MUL;
      end
      S_MUL: begin
        cmd_o.mul_step  = 1'b1;
        cmd_o.mul_first = (cnt_q == 4'd3);
        cnt_d           = cnt_q - 4'd1;
        if (cnt_q == 4'd0) state_d = S_ROUND;
      end
      S_ROUND: begin
        cmd_o.round = 1'b1;
        state_d     = S_WRITE;
      end
      S_WRITE: begin
        cmd_o.write = 1'b1;
        if (row_q) begin
          state_d = S_NEXT;
        end else begin
          row_d   = 1'b1;
          cnt_d   = 4'd3;
          state_d = S_MUL;
        end
      end
      S_NEXT: begin
        cmd_o.next = 1'b1;
        state_d    = status_i.last_site ? S_TRACE : S_ANGLE;
      end
      S_TRACE: begin
        cmd_o.trace = 1'b1;
        state_d     = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
      row_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      row_q   <= row_d;
    end
  end

  assign busy_o = (state_q != S_IDLE);

endmodule

### rtl/htmt_dp.sv
// Datapath for the transfer-matrix trace: modulo and divider steps, cosine
// lookup, split multiplier, product matrix and trace. Uses htmt_pkg.
module htmt_dp (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  htmt_pkg::ctrl_cmd_t   cmd_i,
  output htmt_pkg::dp_status_t  status_o,
  input  logic signed [15:0]    energy_i,
  input  logic [5:0]            alpha_num_i,
  input  logic [6:0]            period_length_i,
  input  logic [15:0]           phase_i,
  output logic [31:0]           trace_magnitude_o,
  output logic                  saturated_o,
  output logic                  valid_o
);

  logic [6:0]         q_q;
  logic [5:0]         p_q;
  logic signed [15:0] e_q;
  logic [6:0]         rem_q;
  logic [15:0]        quot_q;
  logic [15:0]        f_q;
  logic [6:0]         g_q;
  logic [6:0]         site_q;
  logic signed [33:0] cos_q;
  logic               dneg_q;
  logic [35:0]        dmag_q;
  logic [83:0]        acc_q;
  logic signed [47:0] mulv_q;
  logic signed [47:0] pm_q [4];
  logic               sat_q;
  logic [31:0]        res_q;
  logic               rsat_q;
  logic               valid_q;

  logic [6:0]  q_in;
  logic [11:0] qk;
  logic [6:0]  rem_src;
  logic [7:0]  rem2;
  logic        ge;

  always_comb begin
    if (period_length_i == 7'd0) q_in = 7'd1;
    else if (period_length_i > 7'(htmt_pkg::PeriodMax)) q_in = 7'(htmt_pkg::PeriodMax);
    else q_in = period_length_i;
    qk      = {5'd0, q_q} << cmd_i.idx[2:0];
    rem_src = cmd_i.div_first ? {1'b0, p_q} : rem_q;
    rem2    = {rem_src, 1'b0};
    ge      = (rem2 >= {1'b0, q_q});
  end

  // cosine lookup
  logic [15:0] t16;
  logic [15:0] t16r;
  logic [1:0]  quad;
  logic [7:0]  ri;
  logic [8:0]  ti;
  logic [32:0] cmag;
  logic        cneg;

  always_comb begin
    t16  = f_q - phase_i;
    t16r = t16 + 16'd32;
    quad = t16r[15:14];
    ri   = t16r[13:6];
    ti   = quad[0] ? (9'd256 - {1'b0, ri}) : {1'b0, ri};
    cmag = {htmt_pkg::CosTab[ti], 2'b00};
    cneg = quad[0] ^ quad[1];
  end

  // d = E - 2cos
  logic signed [37:0] dval;
  always_comb begin
    dval = 38'(signed'({e_q, 20'd0})) - 38'(cos_q <<< 1);
  end

  // multiplier
  logic signed [47:0] xv;
  logic signed [47:0] yv;
  logic [47:0]        xmag;
  logic [23:0]        ach;
  logic [17:0]        bch;
  logic [41:0]        pp;
  logic [83:0]        pps;

  always_comb begin
    xv   = cmd_i.row ? pm_q[2] : pm_q[0];
    yv   = cmd_i.row ? pm_q[3] : pm_q[1];
    xmag = xv[47] ? 48'(-xv) : 48'(xv);
    ach  = cmd_i.idx[1] ? xmag[47:24] : xmag[23:0];
    bch  = cmd_i.idx[0] ? dmag_q[35:18] : dmag_q[17:0];
    pp   = 42'(ach) * 42'(bch);
    case (cmd_i.idx[1:0])
      2'd0:    pps = {42'd0, pp};
      2'd1:    pps = {24'd0, pp, 18'd0};
      2'd2:    pps = {18'd0, pp, 24'd0};
      default: pps = {pp, 42'd0};
    endcase
  end

  // round, accumulate, clamp
  logic [83:0]        rnd;
  logic [51:0]        rmag;
  logic               rover;
  logic signed [48:0] wsum;
  logic               wover;
  logic               wunder;

  always_comb begin
    rnd    = acc_q + (84'd1 << 31);
    rmag   = rnd[83:32];
    rover  = (rmag > {4'd0, htmt_pkg::EntLim});
    wsum   = 49'(mulv_q) + 49'(yv);
    wover  = (wsum > 49'(signed'(htmt_pkg::EntLim)));
    wunder = (wsum < -49'(signed'(htmt_pkg::EntLim)));
  end

  // trace
  logic signed [48:0] tr;
  logic [48:0]        tmag;
  logic [48:0]        tres;

  always_comb begin
    tr   = 49'(pm_q[0]) + 49'(pm_q[3]);
    tmag = tr[48] ? 49'(-tr) : 49'(tr);
    tres = (tmag + 49'd32768) >> 16;
  end

  logic [6:0] gsum;
  always_comb begin
    gsum = g_q + rem_q;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.init) begin
      q_q    <= q_in;
      p_q    <= alpha_num_i;
      e_q    <= energy_i;
      f_q    <= '0;
      g_q    <= '0;
      site_q <= '0;
      pm_q[0] <= 48'sd1 <<< 32;
      pm_q[1] <= '0;
      pm_q[2] <= '0;
      pm_q[3] <= 48'sd1 <<< 32;
    end
    if (cmd_i.mod_step && ({6'd0, p_q} >= qk)) begin
      p_q <= p_q - qk[5:0];
    end
    if (cmd_i.div_step) begin
      rem_q  <= ge ? 7'(rem2 - {1'b0, q_q}) : rem2[6:0];
      quot_q <= {quot_q[14:0], ge};
    end
    if (cmd_i.angle) begin
      cos_q <= cneg ? -34'(signed'({1'b0, cmag})) : 34'(signed'({1'b0, cmag}));
    end
    if (cmd_i.dset) begin
      dneg_q <= dval[37];
      dmag_q <= dval[37] ? 36'(-dval) : 36'(dval);
    end
    if (cmd_i.mul_step) begin
      acc_q <= cmd_i.mul_first ? pps : acc_q + pps;
    end
    if (cmd_i.round) begin
      if (rover) begin
        mulv_q <= (dneg_q ^ xv[47]) ? -signed'(htmt_pkg::EntLim)
                                    : signed'(htmt_pkg::EntLim);
      end else begin
        mulv_q <= (dneg_q ^ xv[47]) ? -signed'(rmag[47:0]) : signed'(rmag[47:0]);
      end
    end
    if (cmd_i.write) begin
      if (wover) pm_q[{cmd_i.row, 1'b0}] <= signed'(htmt_pkg::EntLim);
      else if (wunder) pm_q[{cmd_i.row, 1'b0}] <= -signed'(htmt_pkg::EntLim);
      else pm_q[{cmd_i.row, 1'b0}] <= wsum[47:0];
      pm_q[{cmd_i.row, 1'b1}] <= -xv;
    end
    if (cmd_i.next) begin
      site_q <= site_q + 7'd1;
      if (gsum >= q_q) begin
        g_q <= gsum - q_q;
        f_q <= f_q + quot_q + 16'd1;
      end else begin
        g_q <= gsum;
        f_q <= f_q + quot_q;
      end
    end
    if (cmd_i.trace) begin
      res_q  <= (tres > 49'hFFFF_FFFF) ? 32'hFFFF_FFFF : tres[31:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sat_q   <= 1'b0;
      rsat_q  <= 1'b0;
      valid_q <= 1'b0;
    end else begin
      valid_q <= cmd_i.trace;
      if (cmd_i.init) sat_q <= 1'b0;
      else if ((cmd_i.round && rover) || (cmd_i.write && (wover || wunder))) sat_q <= 1'b1;
      if (cmd_i.trace) rsat_q <= sat_q || (tres > 49'hFFFF_FFFF);
    end
  end

  assign status_o.last_site = ((site_q + 7'd1) == q_q);
  assign trace_magnitude_o  = res_q;
  assign saturated_o        = rsat_q;
  assign valid_o            = valid_q;

endmodule

### rtl/harper_transfer_matrix_trace.sv
// Top level of the transfer-matrix trace block: configuration registers,
// sequencer and datapath. Uses htmt_pkg, htmt_ctrl and htmt_dp.
//
// Usage: drive energy_i and raise start_i while busy_o is low; the energy
// is taken at that clock edge and busy_o rises. Each item yields exactly
// one result: trace_magnitude_o and saturated_o are presented for a single
// cycle with valid_o high, and that cycle is the transfer.
// Sequence: start step, numerator reduction, flux division, then per site
// the angle step with cosine lookup, operand setup, and for each of two
// matrix entries four partial products on the shared split multiplier,
// rounding and write-back, then the site step; q sites (q from
// period_length, 1 to 64), then trace, then the result cycle.
// One item is in work at a time; busy_o drops in the result cycle, so the
// next start_i may be given then.
// Configuration: cfg_we_i, cfg_idx_i and cfg_wdata_i write alpha_num (0),
// period_length (1) and phase (2); other indices are dropped.
// Write only while busy_o is low.
// Reset: asynchronous, active low; clears the sequencer to idle and loads
// alpha_num = 1, period_length = 1, phase = 0.
// The receiver cannot stall; valid_o is given once per result and not held.
module harper_transfer_matrix_trace (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  output logic               busy_o,
  input  logic signed [15:0] energy_i,
  output logic               valid_o,
  output logic [31:0]        trace_magnitude_o,
  output logic               saturated_o,
  input  logic               cfg_we_i,
  input  logic [1:0]         cfg_idx_i,
  input  logic [15:0]        cfg_wdata_i
);

  logic [5:0]  alpha_q;
  logic [6:0]  period_q;
  logic [15:0] phase_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      alpha_q  <= 6'd1;
      period_q <= 7'd1;
      phase_q  <= 16'd0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        htmt_pkg::CFG_ALPHA:  alpha_q  <= cfg_wdata_i[5:0];
        htmt_pkg::CFG_PERIOD: period_q <= cfg_wdata_i[6:0];
        htmt_pkg::CFG_PHASE:  phase_q  <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  htmt_pkg::ctrl_cmd_t  cmd;
  htmt_pkg::dp_status_t status;

  htmt_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (start_i),
    .busy_o   (busy_o),
    .cmd_o    (cmd),
    .status_i (status)
  );

  htmt_dp u_dp (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cmd_i             (cmd),
    .status_o          (status),
    .energy_i          (energy_i),
    .alpha_num_i       (alpha_q),
    .period_length_i   (period_q),
    .phase_i           (phase_q),
    .trace_magnitude_o (trace_magnitude_o),
    .saturated_o       (saturated_o),
    .valid_o           (valid_o)
  );

endmodule

### tb/tb_top.sv
// Self-checking testbench for harper_transfer_matrix_trace: drives energies
// through the start/busy port and checks every result against a bit-exact
// predictor of the transfer-matrix trace. Depends on htmt_pkg and the RTL.
module tb_top;

  localparam logic [1:0] CfgUnused = 2'd3;
  localparam int unsigned CycleLimit = 5_000_000;
  localparam int unsigned ItemTarget = 550;

  class trace_scoreboard;
    typedef struct {
      logic [31:0] mag;
      logic        sat;
    } trace_res_t;

    trace_res_t  pending[$];
    longint      cos_q32[0:256];
    int unsigned alpha_reg;
    int unsigned period_reg;
    int unsigned phase_reg;
    int unsigned errors;
    bit          sat_seen;

    function new();
      logic [63:0]    theta;
      logic [63:0]    t2;
      logic [63:0]    term;
      longint         acc;
      longint unsigned dv;
      for (int k = 0; k <= 256; k++) begin
        theta = (64'(k) * 64'd1686629713 + 64'd128) >> 8;
        t2    = (theta * theta + (64'd1 << 29)) >> 30;
        term  = 64'd1 << 30;
        acc   = longint'(term);
        for (int n = 1; n <= 8; n++) begin
          dv   = longint'((2 * n - 1) * (2 * n));
          term = ((term * t2) >> 30) / dv;
          if (n % 2 == 1) acc = acc - longint'(term);
          else acc = acc + longint'(term);
        end
        if (acc < 0) acc = 0;
        if (acc > (64'sd1 <<< 30)) acc = 64'sd1 <<< 30;
        cos_q32[k] = acc <<< 2;
      end
      alpha_reg  = 1;
      period_reg = 1;
      phase_reg  = 0;
      errors     = 0;
    endfunction

    function void write_reg(logic [1:0] idx, logic [15:0] val);
      case (idx)
        htmt_pkg::CFG_ALPHA:  alpha_reg  = val & 16'h3f;
        htmt_pkg::CFG_PERIOD: period_reg = val & 16'h7f;
        htmt_pkg::CFG_PHASE:  phase_reg  = val;
        default: ;
      endcase
    endfunction

    function longint cos_turns(logic [15:0] t16);
      int unsigned idx;
      int unsigned r;
      idx = ((int'(t16) + 32) >> 6) & 1023;
      r   = idx & 255;
      case (idx >> 8)
        0: return cos_q32[r];
        1: return -cos_q32[256 - r];
        2: return -cos_q32[r];
        default: return cos_q32[256 - r];
      endcase
    endfunction

    function longint clamp47(longint v);
      if (v > 64'sh7FFF_FFFF_FFFF) begin
        sat_seen = 1;
        return 64'sh7FFF_FFFF_FFFF;
      end
      if (v < -64'sh7FFF_FFFF_FFFF) begin
        sat_seen = 1;
        return -64'sh7FFF_FFFF_FFFF;
      end
      return v;
    endfunction

    function longint mul_q32(longint a, longint b);
      logic [63:0]  ma;
      logic [63:0]  mb;
      logic [127:0] full;
      logic [127:0] mag;
      bit           neg;
      neg  = (a < 0) != (b < 0);
      ma   = a < 0 ? 64'(-a) : 64'(a);
      mb   = b < 0 ? 64'(-b) : 64'(b);
      full = {64'd0, ma} * {64'd0, mb};
      mag  = (full + (128'd1 << 31)) >> 32;
      if (mag > 128'h7FFF_FFFF_FFFF) begin
        sat_seen = 1;
        mag = 128'h7FFF_FFFF_FFFF;
      end
      return neg ? -longint'(mag[63:0]) : longint'(mag[63:0]);
    endfunction

    function void note_energy(logic signed [15:0] energy);
      int unsigned q;
      int unsigned p;
      int unsigned an;
      int unsigned frac;
      longint      e;
      longint      d;
      longint      x;
      longint      y;
      longint      pm[4];
      longint      tr;
      logic [63:0] mag;
      logic [63:0] res;
      trace_res_t  exp_res;
      sat_seen = 0;
      q = period_reg;
      if (q == 0) q = 1;
      if (q > 64) q = 64;
      p  = alpha_reg % q;
      e  = longint'(energy) <<< 20;
      pm = '{64'sd1 <<< 32, 0, 0, 64'sd1 <<< 32};
      an = 0;
      for (int m = 0; m < q; m++) begin
        frac = (an << 16) / q;
        d    = e - 2 * cos_turns(16'(frac - phase_reg));
        for (int i = 0; i < 2; i++) begin
          x = pm[2 * i];
          y = pm[2 * i + 1];
          pm[2 * i]     = clamp47(mul_q32(x, d) + y);
          pm[2 * i + 1] = -x;
        end
        an = (an + p) % q;
      end
      tr  = pm[0] + pm[3];
      mag = tr < 0 ? 64'(-tr) : 64'(tr);
      res = (mag + 64'd32768) >> 16;
      if (res > 64'hFFFF_FFFF) begin
        res = 64'hFFFF_FFFF;
        sat_seen = 1;
      end
      exp_res.mag = res[31:0];
      exp_res.sat = sat_seen;
      pending.push_back(exp_res);
    endfunction

    function void check(logic [31:0] mag, logic sat);
      trace_res_t exp_res;
      if (pending.size() == 0) begin
        $error("unexpected result: trace_magnitude=%0h saturated=%0b", mag, sat);
        errors++;
        return;
      end
      exp_res = pending.pop_front();
      if (mag !== exp_res.mag) begin
        $error("trace_magnitude: expected %0h, actual %0h", exp_res.mag, mag);
        errors++;
      end
      if (sat !== exp_res.sat) begin
        $error("saturated: expected %0b, actual %0b", exp_res.sat, sat);
        errors++;
      end
    endfunction
  endclass

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               start_i = 1'b0;
  logic               busy_o;
  logic signed [15:0] energy_i = '0;
  logic               valid_o;
  logic [31:0]        trace_magnitude_o;
  logic               saturated_o;
  logic               cfg_we_i = 1'b0;
  logic [1:0]         cfg_idx_i = '0;
  logic [15:0]        cfg_wdata_i = '0;

  trace_scoreboard sb = new();
  int unsigned     cycles = 0;
  int unsigned     items_sent = 0;
  bit              idle_on = 1'b1;

  harper_transfer_matrix_trace u_top (
    .clk_i,
    .rst_ni,
    .start_i,
    .busy_o,
    .energy_i,
    .valid_o,
    .trace_magnitude_o,
    .saturated_o,
    .cfg_we_i,
    .cfg_idx_i,
    .cfg_wdata_i
  );

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= CycleLimit) begin
      $display("harper_transfer_matrix_trace regression: fail");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && valid_o) sb.check(trace_magnitude_o, saturated_o);
  end

  // hold start high across back-to-back transfers; lower only for gaps
  task automatic send_energy(logic signed [15:0] energy);
    start_i  <= 1'b1;
    energy_i <= energy;
    do @(posedge clk_i); while (busy_o);
    sb.note_energy(energy);
    items_sent++;
    if (idle_on && $urandom_range(99) < 32) begin
      start_i <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk_i);
    end
  endtask

  task automatic drain();
    start_i <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (3) @(posedge clk_i);
  endtask

  task automatic write_cfg(logic [1:0] idx, logic [15:0] val);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    sb.write_reg(idx, val);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic set_cfg(logic [15:0] alpha, logic [15:0] period, logic [15:0] phase);
    drain();
    write_cfg(htmt_pkg::CFG_ALPHA, alpha);
    write_cfg(htmt_pkg::CFG_PERIOD, period);
    write_cfg(htmt_pkg::CFG_PHASE, phase);
  endtask

  function automatic logic signed [15:0] rand_energy();
    if ($urandom_range(99) < 60) return 16'($signed($urandom_range(0, 24576)) - 12288);
    return 16'($urandom);
  endfunction

  initial begin
    int unsigned per;
    int unsigned phase_no;
    int unsigned burst;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset configuration, energy extremes
    send_energy(16'sd0);
    send_energy(-16'sd32768);
    send_energy(16'sd32767);
    send_energy(16'sd1);
    send_energy(-16'sd1);
    // zero period, unused index, all-ones write data
    set_cfg(16'd3, 16'd0, 16'hFFFF);
    write_cfg(CfgUnused, 16'hFFFF);
    send_energy(16'sd8192);
    send_energy(-16'sd8192);
    // large numerator modulo q
    set_cfg(16'hFFFF, 16'd5, 16'h8000);
    send_energy(16'sd4096);
    send_energy(-16'sd5000);
    // trace saturation with moderate q
    set_cfg(16'd1, 16'd6, 16'd0);
    send_energy(16'sd32767);
    send_energy(-16'sd32768);
    // long period clamps to the maximum; entry saturation
    set_cfg(16'd63, 16'hFFFF, 16'h5555);
    send_energy(16'sd32767);
    send_energy(16'sd2048);
    set_cfg(16'd0, 16'd64, 16'hAAAA);
    send_energy(-16'sd32768);
    send_energy(16'sd1234);
    drain();

    phase_no = 0;
    while (items_sent < ItemTarget) begin
      if ($urandom_range(99) < 80) per = $urandom_range(1, 8);
      else if ($urandom_range(1)) per = $urandom_range(9, 64);
      else per = $urandom_range(65, 127) | ($urandom_range(1) ? 0 : 16'h0380);
      set_cfg(16'($urandom), 16'(per), 16'($urandom));
      idle_on = (phase_no != 3);
      burst = (per > 16 && per < 128) ? 4 : 30;
      repeat (burst) send_energy(rand_energy());
      phase_no++;
    end
    idle_on = 1'b1;

    drain();
    repeat (20) @(posedge clk_i);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("harper_transfer_matrix_trace regression: pass");
    end else begin
      $display("harper_transfer_matrix_trace regression: fail");
    end
    $finish;
  end
endmodule
